>>> rtl/trs_to_affine_matrix_macros.svh
// Assertion macros for the TRS to affine matrix block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TRS_TO_AFFINE_MATRIX_MACROS_SVH
`define TRS_TO_AFFINE_MATRIX_MACROS_SVH
`ifndef SYNTHESIS
`define TRS_ASSERT_SAME(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define TRS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define TRS_ASSERT_SAME(name, clk, rst_n, pre, post)
`define TRS_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/trs_pkg.sv
// Shared widths, constants and types for the TRS to affine matrix block.
// No dependencies; imported by trs_quat_rot and trs_to_affine_matrix.
package trs_pkg;

    localparam int QUAT_W  = 16;
    localparam int QPROD_W = 2 * QUAT_W;
    localparam int ROT_W   = QPROD_W + 2;
    localparam int SCALE_W = 24;
    localparam int TRANS_W = 32;
    localparam int OUT_W   = 32;
    localparam int PROD_W  = ROT_W + SCALE_W;
    localparam int FRAC_SHIFT = 28;
    localparam int MAT_N   = 9;

    localparam logic signed [ROT_W-1:0]   ONE_Q28 = ROT_W'(1) << FRAC_SHIFT;
    localparam logic signed [SCALE_W-1:0] ONE_Q16 = SCALE_W'(1) << 16;

    typedef logic signed [ROT_W-1:0] rot_t;
    typedef rot_t rot_mat_t [MAT_N];

    typedef struct packed {
        logic adv_prod;
        logic adv_rot;
    } rot_ctrl_t;

endpackage

>>> rtl/trs_quat_rot.sv
// Two-stage quaternion to rotation matrix unit (Q2.14 in, Q6.28 out, row-major).
// Depends on trs_pkg; stage enables come from the top-level pipeline control.
module trs_quat_rot
    import trs_pkg::*;
(
    input  logic                      clk,
    input  rot_ctrl_t                 ctrl,
    input  logic                      rot_present,
    input  logic signed [QUAT_W-1:0]  quat_x,
    input  logic signed [QUAT_W-1:0]  quat_y,
    input  logic signed [QUAT_W-1:0]  quat_z,
    input  logic signed [QUAT_W-1:0]  quat_w,
    output rot_mat_t                  rot_mat
);

    logic signed [QPROD_W-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg;
    logic signed [QPROD_W-1:0] yz_reg, xw_reg, yw_reg, zw_reg;
    logic                      present_reg;
    rot_mat_t                  rot_reg;
    rot_mat_t                  rot_next;

    function automatic rot_t ext(input logic signed [QPROD_W-1:0] v);
        return ROT_W'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_prod)
        begin
            present_reg <= rot_present;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;
            xw_reg <= quat_x * quat_w;
            yw_reg <= quat_y * quat_w;
            zw_reg <= quat_z * quat_w;
        end
    end

    always_comb
    begin
        if (present_reg)
        begin
            rot_next[0] = ONE_Q28 - ((ext(yy_reg) + ext(zz_reg)) <<< 1);
            rot_next[1] = (ext(xy_reg) - ext(zw_reg)) <<< 1;
            rot_next[2] = (ext(xz_reg) + ext(yw_reg)) <<< 1;
            rot_next[3] = (ext(xy_reg) + ext(zw_reg)) <<< 1;
            rot_next[4] = ONE_Q28 - ((ext(xx_reg) + ext(zz_reg)) <<< 1);
            rot_next[5] = (ext(yz_reg) - ext(xw_reg)) <<< 1;
            rot_next[6] = (ext(xz_reg) - ext(yw_reg)) <<< 1;
            rot_next[7] = (ext(yz_reg) + ext(xw_reg)) <<< 1;
            rot_next[8] = ONE_Q28 - ((ext(xx_reg) + ext(yy_reg)) <<< 1);
        end
        else
        begin
            for (int k = 0; k < MAT_N; k++)
            begin
                rot_next[k] = ((k % 4) == 0) ? ONE_Q28 : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_rot)
        begin
            rot_reg <= rot_next;
        end
    end

    assign rot_mat = rot_reg;

endmodule

>>> rtl/trs_to_affine_matrix.sv
// Top level of the keyframe TRS to 3x4 affine matrix converter.
// Depends on trs_pkg, trs_quat_rot and trs_to_affine_matrix_macros.svh.
//
// Converts one keyframe (translation, rotation quaternion, scale, presence flags) per
// cycle into the affine matrix T*R*S in Q16.16. Four register stages: quaternion
// products, rotation entries, rotation-times-scale multiply, rounding and saturation.
// Each transaction passes through these stages in order, and a new one is accepted every
// cycle while the output is taken; a stall at the output backs up through the per-stage
// valid bits, filling gaps first, without loss.
`include "trs_to_affine_matrix_macros.svh"

module trs_to_affine_matrix
    import trs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 component_flags,
    input  logic signed [TRANS_W-1:0]  trans_x,
    input  logic signed [TRANS_W-1:0]  trans_y,
    input  logic signed [TRANS_W-1:0]  trans_z,
    input  logic signed [QUAT_W-1:0]   quat_x,
    input  logic signed [QUAT_W-1:0]   quat_y,
    input  logic signed [QUAT_W-1:0]   quat_z,
    input  logic signed [QUAT_W-1:0]   quat_w,
    input  logic signed [SCALE_W-1:0]  scale_x,
    input  logic signed [SCALE_W-1:0]  scale_y,
    input  logic signed [SCALE_W-1:0]  scale_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_W-1:0]    m00,
    output logic signed [OUT_W-1:0]    m01,
    output logic signed [OUT_W-1:0]    m02,
    output logic signed [OUT_W-1:0]    m03,
    output logic signed [OUT_W-1:0]    m10,
    output logic signed [OUT_W-1:0]    m11,
    output logic signed [OUT_W-1:0]    m12,
    output logic signed [OUT_W-1:0]    m13,
    output logic signed [OUT_W-1:0]    m20,
    output logic signed [OUT_W-1:0]    m21,
    output logic signed [OUT_W-1:0]    m22,
    output logic signed [OUT_W-1:0]    m23
);

    localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(1) << (FRAC_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI =
        {{(PROD_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] SAT_LO =
        {{(PROD_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic signed [TRANS_W-1:0] trans1_reg [3];
    logic signed [TRANS_W-1:0] trans2_reg [3];
    logic signed [TRANS_W-1:0] trans3_reg [3];
    logic signed [SCALE_W-1:0] scale1_reg [3];
    logic signed [SCALE_W-1:0] scale2_reg [3];
    logic signed [PROD_W-1:0]  prod3_reg  [MAT_N];
    logic signed [PROD_W-1:0]  prod_next  [MAT_N];
    logic signed [OUT_W-1:0]   out_reg    [12];
    logic signed [OUT_W-1:0]   out_next   [12];

    rot_ctrl_t rot_ctrl;
    rot_mat_t  rot_mat;

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign rot_ctrl.adv_prod = rdy1;
    assign rot_ctrl.adv_rot  = rdy2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    trs_quat_rot u_rot (
        .clk         (clk),
        .ctrl        (rot_ctrl),
        .rot_present (component_flags[1]),
        .quat_x      (quat_x),
        .quat_y      (quat_y),
        .quat_z      (quat_z),
        .quat_w      (quat_w),
        .rot_mat     (rot_mat)
    );

    // absent factors resolved on entry: zero translation, unit scale
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            trans1_reg[0] <= component_flags[0] ? trans_x : '0;
            trans1_reg[1] <= component_flags[0] ? trans_y : '0;
            trans1_reg[2] <= component_flags[0] ? trans_z : '0;
            scale1_reg[0] <= component_flags[2] ? scale_x : ONE_Q16;
            scale1_reg[1] <= component_flags[2] ? scale_y : ONE_Q16;
            scale1_reg[2] <= component_flags[2] ? scale_z : ONE_Q16;
        end
        if (rdy2)
        begin
            trans2_reg <= trans1_reg;
            scale2_reg <= scale1_reg;
        end
        if (rdy3)
        begin
            trans3_reg <= trans2_reg;
            prod3_reg  <= prod_next;
        end
        if (rdy4)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAT_N; k++)
        begin
            prod_next[k] = rot_mat[k] * scale2_reg[k % 3];
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] rnd;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rnd = (prod3_reg[i*3+j] + HALF) >>> FRAC_SHIFT;
                if (rnd > SAT_HI)
                    out_next[i*4+j] = SAT_HI[OUT_W-1:0];
                else if (rnd < SAT_LO)
                    out_next[i*4+j] = SAT_LO[OUT_W-1:0];
                else
                    out_next[i*4+j] = rnd[OUT_W-1:0];
            end
            out_next[i*4+3] = trans3_reg[i];
        end
    end

    assign out_valid = v4_reg;
    assign m00 = out_reg[0];
    assign m01 = out_reg[1];
    assign m02 = out_reg[2];
    assign m03 = out_reg[3];
    assign m10 = out_reg[4];
    assign m11 = out_reg[5];
    assign m12 = out_reg[6];
    assign m13 = out_reg[7];
    assign m20 = out_reg[8];
    assign m21 = out_reg[9];
    assign m22 = out_reg[10];
    assign m23 = out_reg[11];

    `TRS_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && in_ready, v1_reg)
    `TRS_ASSERT_NEXT(a_s3_held_on_stall, clk, rst_n, v3_reg && !rdy4, v3_reg && v4_reg)
    `TRS_ASSERT_NEXT(a_empty_no_output, clk, rst_n,
        !v1_reg && !v2_reg && !v3_reg && !v4_reg, !out_valid)

endmodule
